FILE: rtl/svg_pkg.sv
`default_nettype none
package svg_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 24;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_ITERS = 16;

  localparam int UDIM_W  = COORD_BITS - 1;
  localparam int CNT_W   = $clog2(MAX_VERTICES) + 1;
  localparam int IDX_W   = $clog2(MAX_VERTICES);
  localparam int ANG_W   = 32;
  localparam int NUM_W   = ANG_W + IDX_W;
  localparam int DEN_W   = CNT_W;
  localparam int DSTEP_W = $clog2(NUM_W);
  localparam int ATAN_IDX_W = 5;
  localparam int CR_W    = 34;
  localparam int TRIG_W  = 32;
  localparam int SUM_W   = COORD_BITS + 4;
  localparam int PROD_W  = UDIM_W + 1 + TRIG_W;
  localparam int OFF_W   = PROD_W - 30;

  localparam logic [ANG_W-1:0] QUARTER  = 32'h4000_0000;
  localparam logic [ANG_W-1:0] HALF     = 32'h8000_0000;
  localparam logic [CR_W-1:0]  CORDIC_K = CR_W'(652032874);

  localparam logic [2:0] CMD_RECT    = 3'd0;
  localparam logic [2:0] CMD_ROUNDED = 3'd1;
  localparam logic [2:0] CMD_RHOMBUS = 3'd2;
  localparam logic [2:0] CMD_CIRCLE  = 3'd3;
  localparam logic [2:0] CMD_PIE     = 3'd4;
  localparam logic [2:0] CMD_STAR    = 3'd5;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_W-1:0] wide_t;

  function automatic logic [ANG_W-1:0] atan_val(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANG_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic coord_t sat_coord(input wide_t v);
    wide_t hi;
    wide_t lo;
    coord_t res;
    hi = SUM_W'({1'b0, {(COORD_BITS-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      res = hi[COORD_BITS-1:0];
    end else if (v < lo) begin
      res = lo[COORD_BITS-1:0];
    end else begin
      res = v[COORD_BITS-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/svg_divider.sv
`default_nettype none
module svg_divider
  import svg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [ANG_W-1:0]      quo
);

  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [NUM_W-1:0]   q_r, q_nxt;
  logic [DEN_W-1:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0]   den_r;
  logic [DSTEP_W-1:0] step_r, step_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DEN_W:0]     trial;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial    = {rem_r, num_r[NUM_W-1]};
    num_nxt  = num_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      step_nxt = step_r + DSTEP_W'(1);
      if (step_r == DSTEP_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quo  = q_r[ANG_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/svg_cordic.sv
`default_nettype none
module svg_cordic
  import svg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [ANG_W-1:0] angle,
  output logic                  done,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  logic signed [CR_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [CR_W-1:0] dx, dy, at;
  logic [ATAN_IDX_W-1:0]  step_r, step_nxt;
  logic                   busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [ANG_W-1:0]       a_adj, a_sum;
  logic signed [TRIG_W-1:0] cos_r, cos_nxt, sin_r, sin_nxt;

  always_comb begin
    a_sum    = angle + QUARTER;
    a_adj    = a_sum[ANG_W-1] ? angle + HALF : angle;
    dx       = y_r >>> step_r;
    dy       = x_r >>> step_r;
    at       = $signed(CR_W'(atan_val(step_r)));
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    cos_nxt  = cos_r;
    sin_nxt  = sin_r;
    if (start) begin
      // Angles in the left half plane are turned by a half turn first.
      neg_nxt  = a_sum[ANG_W-1];
      x_nxt    = $signed(CORDIC_K);
      y_nxt    = '0;
      z_nxt    = CR_W'($signed(a_adj));
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[CR_W-1]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end
      step_nxt = step_r + ATAN_IDX_W'(1);
      if (step_r == ATAN_IDX_W'(CORDIC_ITERS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        cos_nxt  = neg_r ? TRIG_W'(-x_nxt) : TRIG_W'(x_nxt);
        sin_nxt  = neg_r ? TRIG_W'(-y_nxt) : TRIG_W'(y_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
    cos_r  <= cos_nxt;
    sin_r  <= sin_nxt;
  end

  assign done  = done_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule
`default_nettype wire

FILE: rtl/shape_vertex_generator_top.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | command, pos, size, radii, count, angles
// out_    | output    | out_valid/out_stall| vertex_x, vertex_y, vertex_index, last
// Rectangle, rhombus and pie apex vertices go from S_NEXT straight to S_OUT. An arc
// vertex is issued in S_NEXT, then passes the bit-serial angle divider (S_DIV), the
// CORDIC rotation (S_COR), the shared multiplier that scales cosine and sine by the
// radius (S_MX, S_MY) and the output beat (S_OUT). A request holds up to 64 vertices.
// Reset is synchronous and active low. The input is stalled for the whole request,
// and the sequencer waits on a stalled output beat before working on the next vertex.
`default_nettype none
module shape_vertex_generator_top
  import svg_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [2:0]             in_command,
  input  wire logic signed [COORD_BITS-1:0] in_pos_x,
  input  wire logic signed [COORD_BITS-1:0] in_pos_y,
  input  wire logic [UDIM_W-1:0]      in_width,
  input  wire logic [UDIM_W-1:0]      in_height,
  input  wire logic [UDIM_W-1:0]      in_radius,
  input  wire logic [UDIM_W-1:0]      in_inner_radius,
  input  wire logic [CNT_W-1:0]       in_count,
  input  wire logic [ANGLE_BITS-1:0]  in_angle_from,
  input  wire logic [ANGLE_BITS-1:0]  in_angle_to,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [COORD_BITS-1:0] out_vertex_x,
  output logic signed [COORD_BITS-1:0] out_vertex_y,
  output logic [IDX_W-1:0]            out_vertex_index,
  output logic                        out_last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NEXT = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_COR  = 3'd3;
  localparam logic [2:0] S_MX   = 3'd4;
  localparam logic [2:0] S_MY   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;

  logic [2:0]             cmd_r;
  coord_t                 px_r, py_r;
  logic [UDIM_W-1:0]      w_r, h_r, r_r, ri_r;
  logic [CNT_W-1:0]       n_r, total_r;
  logic [ANG_W-1:0]       af_r, sect_r;
  logic [CNT_W-1:0]       k_r, k_nxt;
  logic [IDX_W-1:0]       i_r, i_nxt;
  logic [1:0]             corner_r, corner_nxt;
  coord_t                 vx_r, vx_nxt, vy_r, vy_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;

  // Request decode.
  logic [2:0]        cmd_eff;
  logic [CNT_W-1:0]  n_eff, total_eff;
  logic [UDIM_W-1:0] r_eff, half_w, half_h;
  logic [ANG_W-1:0]  af_in, at_in;

  always_comb begin
    half_w  = in_width >> 1;
    half_h  = in_height >> 1;
    cmd_eff = in_command;
    if (in_command == CMD_ROUNDED && in_count < CNT_W'(2)) begin
      cmd_eff = CMD_RECT;
    end
    r_eff = in_radius;
    if (r_eff > half_h) r_eff = half_h;
    if (r_eff > half_w) r_eff = half_w;
    n_eff     = in_count;
    total_eff = '0;
    unique case (cmd_eff)
      CMD_RECT, CMD_RHOMBUS: total_eff = CNT_W'(4);
      CMD_ROUNDED: begin
        if (n_eff > CNT_W'(MAX_VERTICES / 4)) n_eff = CNT_W'(MAX_VERTICES / 4);
        total_eff = CNT_W'(n_eff << 2);
      end
      CMD_CIRCLE, CMD_PIE: begin
        if (n_eff < CNT_W'(3)) n_eff = CNT_W'(3);
        if (n_eff > CNT_W'(MAX_VERTICES)) n_eff = CNT_W'(MAX_VERTICES);
        total_eff = n_eff;
      end
      CMD_STAR: begin
        if (n_eff > CNT_W'(MAX_VERTICES / 2)) n_eff = CNT_W'(MAX_VERTICES / 2);
        total_eff = CNT_W'(n_eff << 1);
      end
      default: total_eff = '0;
    endcase
    af_in = {in_angle_from, {(ANG_W-ANGLE_BITS){1'b0}}};
    at_in = {in_angle_to, {(ANG_W-ANGLE_BITS){1'b0}}};
  end

  // Divider and CORDIC.
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, pie_num;
  logic [DEN_W-1:0] div_den;
  logic [ANG_W-1:0] quo, angle;
  logic             cor_start, cor_done;
  logic signed [TRIG_W-1:0] cos_v, sin_v;

  svg_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  svg_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (angle),
    .done  (cor_done),
    .cos_o (cos_v),
    .sin_o (sin_v)
  );

  always_comb begin
    pie_num = NUM_W'(i_r) * NUM_W'(sect_r);
    div_num = '0;
    div_den = n_r;
    angle   = quo - QUARTER;
    unique case (cmd_r)
      CMD_ROUNDED: begin
        div_num = NUM_W'(i_r) << 30;
        div_den = n_r - CNT_W'(1);
        angle   = quo + {corner_r, {(ANG_W-2){1'b0}}} + HALF;
      end
      CMD_PIE: begin
        div_num = pie_num;
        div_den = n_r - CNT_W'(1);
        angle   = af_r + quo;
      end
      CMD_STAR: div_num = NUM_W'(i_r) << 31;
      default:  div_num = NUM_W'(i_r) << 32;
    endcase
  end

  // Arc centre and radius for the current vertex.
  wide_t             pxw, pyw, wx, hy, rw, cx, cy, off_w;
  logic [UDIM_W-1:0] rad;
  logic signed [PROD_W-1:0] rounded_prod;
  logic signed [TRIG_W-1:0] trig_sel;

  always_comb begin
    pxw = SUM_W'(px_r);
    pyw = SUM_W'(py_r);
    wx  = SUM_W'({1'b0, w_r});
    hy  = SUM_W'({1'b0, h_r});
    rw  = SUM_W'({1'b0, r_r});
    cx  = pxw;
    cy  = pyw;
    if (cmd_r == CMD_ROUNDED) begin
      cx = (corner_r == 2'd1 || corner_r == 2'd2) ? pxw + wx - rw : pxw + rw;
      cy = corner_r[1] ? pyw + hy - rw : pyw + rw;
    end
    rad = (cmd_r == CMD_STAR && i_r[0]) ? ri_r : r_r;
    rounded_prod = prod_r + (PROD_W'(1) <<< 29);
    off_w = SUM_W'($signed(rounded_prod[PROD_W-1:30]));
    trig_sel = (state_r == S_COR) ? cos_v : sin_v;
  end

  // Fixed vertices of rectangle, rhombus and pie apex.
  wide_t fx, fy;
  always_comb begin
    fx = pxw;
    fy = pyw;
    if (cmd_r == CMD_RECT) begin
      if (k_r == CNT_W'(1) || k_r == CNT_W'(2)) fx = pxw + wx;
      if (k_r == CNT_W'(2) || k_r == CNT_W'(3)) fy = pyw + hy;
    end else if (cmd_r == CMD_RHOMBUS) begin
      unique case (k_r[1:0])
        2'd0: fx = pxw + (wx >>> 1);
        2'd1: begin
          fx = pxw + wx;
          fy = pyw + (hy >>> 1);
        end
        2'd2: begin
          fx = pxw + (wx >>> 1);
          fy = pyw + hy;
        end
        default: fy = pyw + (hy >>> 1);
      endcase
    end
  end

  logic is_fixed, is_last;
  assign is_fixed = (cmd_r == CMD_RECT) || (cmd_r == CMD_RHOMBUS) ||
                    (cmd_r == CMD_PIE && k_r == '0);
  assign is_last  = (k_r == total_r - CNT_W'(1));

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    i_nxt      = i_r;
    corner_nxt = corner_r;
    vx_nxt     = vx_r;
    vy_nxt     = vy_r;
    prod_nxt   = prod_r;
    div_start  = 1'b0;
    cor_start  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        k_nxt      = '0;
        i_nxt      = '0;
        corner_nxt = '0;
        if (in_valid && total_eff != '0) begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (is_fixed) begin
          vx_nxt    = sat_coord(fx);
          vy_nxt    = sat_coord(fy);
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          cor_start = 1'b1;
          state_nxt = S_COR;
        end
      end
      S_COR: begin
        if (cor_done) begin
          prod_nxt  = $signed({1'b0, rad}) * trig_sel;
          state_nxt = S_MX;
        end
      end
      S_MX: begin
        vx_nxt    = sat_coord(cx + off_w);
        prod_nxt  = $signed({1'b0, rad}) * trig_sel;
        state_nxt = S_MY;
      end
      S_MY: begin
        vy_nxt    = sat_coord(cy + off_w);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          k_nxt = k_r + CNT_W'(1);
          if (!is_fixed) begin
            if (cmd_r == CMD_ROUNDED && i_r == IDX_W'(n_r - CNT_W'(1))) begin
              i_nxt      = '0;
              corner_nxt = corner_r + 2'd1;
            end else begin
              i_nxt = i_r + IDX_W'(1);
            end
          end
          state_nxt = is_last ? S_IDLE : S_NEXT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    i_r      <= i_nxt;
    corner_r <= corner_nxt;
    vx_r     <= vx_nxt;
    vy_r     <= vy_nxt;
    prod_r   <= prod_nxt;
    if (state_r == S_IDLE && in_valid) begin
      cmd_r   <= cmd_eff;
      px_r    <= in_pos_x;
      py_r    <= in_pos_y;
      w_r     <= in_width;
      h_r     <= in_height;
      r_r     <= (cmd_eff == CMD_ROUNDED) ? r_eff : in_radius;
      ri_r    <= in_inner_radius;
      n_r     <= n_eff;
      total_r <= total_eff;
      af_r    <= af_in;
      sect_r  <= at_in - af_in;
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign out_vertex_x     = vx_r;
  assign out_vertex_y     = vy_r;
  assign out_vertex_index = k_r[IDX_W-1:0];
  assign out_last         = is_last;

endmodule
`default_nettype wire
